@@ rtl/lfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants, codes and the response word type for the LFU cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_COUNT_BITS = 16;

    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request kind carried on tuser
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    localparam logic [VALUE_W-1:0] MISS_VALUE = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] PUT_VALUE  = {VALUE_W{1'b0}};

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
    } rsp_t;

endpackage

@@ rtl/lfu_replacement_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU replacement cache
// Fully associative key-value store, least-frequently-used eviction with
// least-recently-used choice among equal use counts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as words on the s_ channel: s_tuser is the mode (get or
//   put), s_tdata carries the key and the value to store. Each request gives
//   exactly one response word on the m_ channel: m_tuser is the hit flag,
//   m_tdata the read value (stored value on a get hit, all ones on a get
//   miss, zero for any put).
//   Pipeline: an input register, then the lookup, victim search and store
//   update in one combinational pass into the response register, whose
//   valid flag drives m_tvalid. One word per cycle is sustained while the
//   receiver keeps m_tready high.
//   A stalled receiver holds the response register; the input register then
//   holds its word and s_tready drops once both are full. No word is lost.
//   Reset empties the store (all entries invalid), clears both pipeline
//   valid flags and sets capacity_in_use to sixteen. Write capacity_in_use
//   through cfg_wen/cfg_wdata only while no request is in flight.
// ----------------------------------------------------------------------------
module lfu_replacement_cache #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS,
    parameter int IN_DATA_W  = ((KEY_BITS + lfu_pkg::VALUE_W + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: capacity_in_use
    input  logic                         cfg_wen,
    input  logic [lfu_pkg::CAP_W-1:0]    cfg_wdata,
    // request channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [IN_DATA_W-1:0]         s_tdata,   // lookup_key, write_value, zero pad
    input  logic                         s_tuser,   // mode
    // response channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lfu_pkg::VALUE_W-1:0]  m_tdata,   // read_value
    output logic                         m_tuser    // hit
);

    logic                         in_valid_reg, in_valid_next;
    logic                         in_put_reg;
    logic [KEY_BITS-1:0]          in_key_reg;
    logic [lfu_pkg::VALUE_W-1:0]  in_value_reg;
    logic                         out_valid_reg, out_valid_next;
    lfu_pkg::rsp_t                out_rsp_reg;
    logic [lfu_pkg::CAP_W-1:0]    cap_reg;
    lfu_pkg::rsp_t                core_rsp;
    logic                         advance;
    logic                         take;

    // advance the held word into the store when the response slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= lfu_pkg::CAP_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // payload: hold unless a new word is taken / a response is produced
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_put_reg   <= (s_tuser == lfu_pkg::MODE_PUT);
            in_key_reg   <= s_tdata[KEY_BITS-1:0];
            in_value_reg <= s_tdata[KEY_BITS +: lfu_pkg::VALUE_W];
        end
        if (advance)
        begin
            out_rsp_reg <= core_rsp;
        end
    end

    lfu_core #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .do_step   (advance),
        .req_put   (in_put_reg),
        .req_key   (in_key_reg),
        .req_value (in_value_reg),
        .capacity  (cap_reg),
        .rsp       (core_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rsp_reg.read_value;
    assign m_tuser  = out_rsp_reg.hit;

endmodule

@@ rtl/lfu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache core
// Entry store, parallel key match, victim tree and state update.
// ----------------------------------------------------------------------------
module lfu_core #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       do_step,
    input  logic                       req_put,
    input  logic [KEY_BITS-1:0]        req_key,
    input  logic [lfu_pkg::VALUE_W-1:0] req_value,
    input  logic [lfu_pkg::CAP_W-1:0]  capacity,
    output lfu_pkg::rsp_t              rsp
);

    localparam int RANK_W  = $clog2(ENTRIES);
    localparam int IDX_W   = RANK_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
    localparam int LEVELS  = $clog2(ENTRIES);
    localparam int P2      = 1 << LEVELS;
    localparam int SCORE_W = 1 + COUNT_BITS + RANK_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [ENTRIES-1:0]              valid_reg, valid_next;
    logic [KEY_BITS-1:0]             key_reg   [ENTRIES];
    logic [KEY_BITS-1:0]             key_next  [ENTRIES];
    logic [lfu_pkg::VALUE_W-1:0]     value_reg [ENTRIES];
    logic [lfu_pkg::VALUE_W-1:0]     value_next[ENTRIES];
    logic [COUNT_BITS-1:0]           count_reg [ENTRIES];
    logic [COUNT_BITS-1:0]           count_next[ENTRIES];
    logic [RANK_W-1:0]               rank_reg  [ENTRIES];
    logic [RANK_W-1:0]               rank_next [ENTRIES];
    logic [OCC_W-1:0]                occ_reg, occ_next;

    logic [SCORE_W-1:0] node_score[1:2*P2-1];
    logic [IDX_W-1:0]   node_idx  [1:2*P2-1];

    logic [ENTRIES-1:0]          hit_vec;
    logic [ENTRIES-1:0]          vic_hot;
    logic [ENTRIES-1:0]          free_vec;
    logic [ENTRIES-1:0]          ins_hot;
    logic                        found;
    logic                        put_miss;
    logic                        evict;
    logic [RANK_W-1:0]           hit_rank;
    logic [RANK_W-1:0]           vic_rank;
    logic [lfu_pkg::VALUE_W-1:0] hit_value;
    logic [CMP_W-1:0]            cap_ext;
    logic [CMP_W-1:0]            eff_cap;

    // victim tree: lowest score wins; score orders by count, then oldest rank;
    // an empty entry scores all ones so its stale contents never take part
    genvar g;
    generate
        for (g = 0; g < P2; g++) begin : g_leaf
            if (g < ENTRIES) begin : g_real
                assign node_score[P2+g] = valid_reg[g] ?
                                          {1'b0, count_reg[g], ~rank_reg[g]} :
                                          {SCORE_W{1'b1}};
                assign node_idx[P2+g]   = IDX_W'(g);
            end
            else begin : g_pad
                assign node_score[P2+g] = {SCORE_W{1'b1}};
                assign node_idx[P2+g]   = '0;
            end
        end
        for (g = 1; g < P2; g++) begin : g_node
            assign node_score[g] = (node_score[2*g] <= node_score[2*g+1]) ?
                                   node_score[2*g] : node_score[2*g+1];
            assign node_idx[g]   = (node_score[2*g] <= node_score[2*g+1]) ?
                                   node_idx[2*g] : node_idx[2*g+1];
        end
    endgenerate

    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (capacity == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        vic_rank  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == req_key);
        end
        found    = |hit_vec;
        put_miss = req_put && !found;
        evict    = put_miss && (CMP_W'(occ_reg) >= eff_cap);
        for (int i = 0; i < ENTRIES; i++)
        begin
            vic_hot[i] = evict && (node_idx[1] == IDX_W'(i));
            hit_rank   = hit_rank  | (hit_vec[i] ? rank_reg[i]  : '0);
            hit_value  = hit_value | (hit_vec[i] ? value_reg[i] : '0);
            vic_rank   = vic_rank  | (vic_hot[i] ? rank_reg[i]  : '0);
        end
        // free slots once the victim has gone; take the lowest one
        free_vec = ~valid_reg | vic_hot;
        ins_hot  = free_vec & (~free_vec + 1'b1);
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];
        end
        if (do_step && found)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (hit_vec[i])
                begin
                    rank_next[i] = '0;
                    if (count_reg[i] != COUNT_MAX)
                    begin
                        count_next[i] = count_reg[i] + 1'b1;
                    end
                    if (req_put)
                    begin
                        value_next[i] = req_value;
                    end
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
        else if (do_step && put_miss)
        begin
            valid_next = (valid_reg & ~vic_hot) | ins_hot;
            if (!evict)
            begin
                occ_next = occ_reg + 1'b1;
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (ins_hot[i])
                begin
                    key_next[i]   = req_key;
                    value_next[i] = req_value;
                    count_next[i] = COUNT_BITS'(1);
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i] && !vic_hot[i])
                begin
                    // close the victim's gap, then age by one for the new entry
                    if (!(evict && (rank_reg[i] > vic_rank)))
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        rsp.hit = found;
        if (req_put)
        begin
            rsp.read_value = lfu_pkg::PUT_VALUE;
        end
        else if (found)
        begin
            rsp.read_value = hit_value;
        end
        else
        begin
            rsp.read_value = lfu_pkg::MISS_VALUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i]   <= key_next[i];
            value_reg[i] <= value_next[i];
            count_reg[i] <= count_next[i];
            rank_reg[i]  <= rank_next[i];
        end
    end

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy count disagrees with valid entries");

    a_occ_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(ENTRIES))
        else $error("occupancy above entry count");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        do_step |-> $onehot0(hit_vec))
        else $error("key present in more than one entry");

    a_put_fills: assert property (@(posedge clk) disable iff (!rst_n)
        do_step && put_miss |=> valid_reg != '0)
        else $error("put miss left the store empty");

endmodule
